### hw/rtl/pva_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the polyphonic voice allocator.
// Used by every module of the block; depends on nothing.
package pva_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int AGE_W = 32;

	typedef struct packed {
		logic       func;
		logic [6:0] value;
	} pva_in_t;

	typedef struct packed {
		logic [4:0] voice;
		logic [6:0] pitch;
		logic [6:0] velocity;
		logic       last;
	} pva_out_t;

	typedef enum logic {
		FUNC_NOTE = 1'b0,
		FUNC_SET_VEL = 1'b1
	} pva_func_t;

	typedef enum logic {
		CMD_ON = 1'b0,
		CMD_OFF = 1'b1
	} pva_kind_t;

	typedef struct packed {
		pva_kind_t  kind;
		logic [6:0] pitch;
		logic [6:0] velocity;
	} pva_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pva_qstat_t;

	typedef struct packed {
		logic [4:0] active_voices;
		logic       steal_enable;
	} pva_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_STEAL
	} pva_state_t;

	typedef enum logic {
		REG_ACTIVE_VOICES = 1'b0,
		REG_STEAL_ENABLE = 1'b1
	} pva_reg_t;

endpackage

### hw/rtl/pva_front.sv
`timescale 1ns / 1ps
// Front end: accepts input items, keeps the held velocity and classifies notes.
// Depends on pva_pkg; feeds the command queue.
module pva_front import pva_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  pva_in_t    item,
	input  pva_qstat_t qstat,
	output logic       busy,
	output logic       push,
	output pva_cmd_t   cmd
);

	logic [6:0] held_velocity_q;
	logic       accept;

	assign busy = qstat.full;
	assign accept = start && !qstat.full;

	// Velocity changes are applied here in arrival order, so every queued note
	// already carries the velocity that was held when it arrived.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_velocity_q <= 7'd0;
		end else if (accept && item.func == FUNC_SET_VEL) begin
			held_velocity_q <= item.value;
		end
	end

	assign push = accept && item.func == FUNC_NOTE;

	always_comb begin
		cmd.kind = (held_velocity_q != 7'd0) ? CMD_ON : CMD_OFF;
		cmd.pitch = item.value;
		cmd.velocity = held_velocity_q;
	end

endmodule

### hw/rtl/pva_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the voice engine.
// Depends on pva_pkg for the command type and depth.
module pva_fifo import pva_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pva_cmd_t   cmd_in,
	input  logic       pop,
	output pva_cmd_t   cmd_out,
	output pva_qstat_t qstat
);

	localparam int CNT_W = $clog2(QDEPTH + 1);

	pva_cmd_t           entry_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign qstat.full = (count_q == CNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push = push && !qstat.full;
	assign do_pop = pop && !qstat.empty;
	assign cmd_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/pva_engine.sv
`timescale 1ns / 1ps
// Voice engine: scans the voice table one entry a cycle, picks the voice and
// sends the on and off messages. Depends on pva_pkg.
module pva_engine import pva_pkg::*; #(
	parameter int MAX_VOICES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  pva_cfg_t   cfg,
	input  pva_qstat_t qstat,
	input  pva_cmd_t   cmd_in,
	output logic       pop,
	output logic       result_valid,
	output pva_out_t   result
);

	localparam int IDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int CNT_W = $clog2(MAX_VOICES + 1);
	localparam int ROW_W = 7 + AGE_W;

	pva_state_t state_q, state_d;

	// Voice table: pitch and age per voice, one write and one read port.
	logic [ROW_W-1:0]      mem [MAX_VOICES];
	logic [MAX_VOICES-1:0] written_q;
	logic [MAX_VOICES-1:0] busy_q;

	pva_cmd_t          cmd_q;
	logic [CNT_W-1:0]  scan_q;
	logic [CNT_W-1:0]  n_voices;
	logic [AGE_W-1:0]  counter_q;

	logic [ROW_W-1:0]  rd_row_s1;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              cmp_s1;

	logic              have_on_q, have_off_q;
	logic [IDX_W-1:0]  on_idx_q, off_idx_q;
	logic [AGE_W-1:0]  on_age_q, off_age_q;
	logic [6:0]        on_pitch_q;

	logic [6:0]        row_pitch;
	logic [AGE_W-1:0]  row_age;
	logic              row_busy;
	logic              take_on, take_off;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [6:0]        wr_pitch;
	logic              set_busy, clr_busy;
	logic              res_vld_d;
	pva_out_t          res_d;
	logic [IDX_W-1:0]  res_idx;
	logic [31:0]       voice_num;

	always_comb begin
		if (cfg.active_voices == 5'd0) begin
			n_voices = CNT_W'(1);
		end else if (32'(cfg.active_voices) > 32'(MAX_VOICES)) begin
			n_voices = CNT_W'(MAX_VOICES);
		end else begin
			n_voices = CNT_W'(cfg.active_voices);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!qstat.empty) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_q == n_voices - 1'b1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (cmd_q.kind == CMD_ON && !have_off_q && have_on_q && cfg.steal_enable) begin
					state_d = ST_STEAL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_STEAL: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of each state: table writes and the result for this cycle.
	always_comb begin
		pop = 1'b0;
		wr_en = 1'b0;
		wr_idx = off_idx_q;
		wr_pitch = cmd_q.pitch;
		set_busy = 1'b0;
		clr_busy = 1'b0;
		res_vld_d = 1'b0;
		res_idx = off_idx_q;
		res_d.pitch = cmd_q.pitch;
		res_d.velocity = cmd_q.velocity;
		res_d.last = 1'b1;
		case (state_q)
			ST_IDLE: pop = !qstat.empty;
			ST_DECIDE: begin
				if (cmd_q.kind == CMD_ON) begin
					if (have_off_q) begin
						wr_en = 1'b1;
						set_busy = 1'b1;
						res_vld_d = 1'b1;
					end else if (have_on_q && cfg.steal_enable) begin
						// First half of a steal: silence the old note.
						res_vld_d = 1'b1;
						res_idx = on_idx_q;
						res_d.pitch = on_pitch_q;
						res_d.velocity = 7'd0;
						res_d.last = 1'b0;
					end
				end else if (have_on_q) begin
					wr_en = 1'b1;
					wr_idx = on_idx_q;
					wr_pitch = on_pitch_q;
					clr_busy = 1'b1;
					res_vld_d = 1'b1;
					res_idx = on_idx_q;
					res_d.pitch = on_pitch_q;
					res_d.velocity = 7'd0;
				end
			end
			ST_STEAL: begin
				wr_en = 1'b1;
				wr_idx = on_idx_q;
				res_vld_d = 1'b1;
				res_idx = on_idx_q;
			end
			default: ;
		endcase
		voice_num = 32'(res_idx) + 32'd1;
		res_d.voice = voice_num[4:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= {wr_pitch, counter_q};
		end
		rd_row_s1 <= mem[scan_q[IDX_W-1:0]];
		rd_vld_s1 <= written_q[scan_q[IDX_W-1:0]];
		idx_s1 <= scan_q[IDX_W-1:0];
		if (state_q == ST_IDLE) begin
			cmd_q <= cmd_in;
		end
		if (res_vld_d) begin
			result <= res_d;
		end
	end

	// An entry never written reads as pitch zero, age zero.
	assign row_pitch = rd_vld_s1 ? rd_row_s1[ROW_W-1 -: 7] : 7'd0;
	assign row_age = rd_vld_s1 ? rd_row_s1[AGE_W-1:0] : '0;
	assign row_busy = busy_q[idx_s1];
	// For a note off, the busy tracker only considers voices holding the pitch.
	assign take_on = cmp_s1 && row_busy && (cmd_q.kind == CMD_ON || row_pitch == cmd_q.pitch)
		&& (!have_on_q || row_age < on_age_q);
	assign take_off = cmp_s1 && !row_busy && (!have_off_q || row_age < off_age_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q <= '0;
			cmp_s1 <= 1'b0;
			counter_q <= '0;
			written_q <= '0;
			busy_q <= '0;
			have_on_q <= 1'b0;
			have_off_q <= 1'b0;
			on_idx_q <= '0;
			off_idx_q <= '0;
			on_age_q <= '0;
			off_age_q <= '0;
			on_pitch_q <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			cmp_s1 <= (state_q == ST_SCAN);
			result_valid <= res_vld_d;
			if (state_q == ST_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end else begin
				scan_q <= '0;
			end
			if (state_q == ST_IDLE) begin
				have_on_q <= 1'b0;
				have_off_q <= 1'b0;
			end else begin
				if (take_on) begin
					have_on_q <= 1'b1;
					on_idx_q <= idx_s1;
					on_age_q <= row_age;
					on_pitch_q <= row_pitch;
				end
				if (take_off) begin
					have_off_q <= 1'b1;
					off_idx_q <= idx_s1;
					off_age_q <= row_age;
				end
			end
			if (wr_en) begin
				written_q[wr_idx] <= 1'b1;
				counter_q <= counter_q + 1'b1;
			end
			if (set_busy) begin
				busy_q[wr_idx] <= 1'b1;
			end
			if (clr_busy) begin
				busy_q[wr_idx] <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/polyphonic_voice_allocator_core.sv
`timescale 1ns / 1ps
// Polyphonic voice allocator: a velocity setting is absorbed by the front end in
// the cycle it is taken; a note waits in a two-entry command queue and the voice
// engine then scans the active voices one per cycle, giving at most one result,
// or two when it steals a voice.
// start is taken whenever busy is low; busy is high only while the queue is full.
// Each result appears for one cycle with result_valid high and cannot be held off;
// the two results of a steal come in consecutive cycles. Depends on pva_pkg.
module polyphonic_voice_allocator_core import pva_pkg::*; #(
	parameter int MAX_VOICES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  pva_in_t     item,
	output logic        busy,
	output logic        result_valid,
	output pva_out_t    result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	pva_cfg_t   cfg_q;
	pva_qstat_t qstat;
	pva_cmd_t   push_cmd, head_cmd;
	logic       push, pop;
	pva_reg_t   reg_sel;

	assign pready = 1'b1;
	assign reg_sel = pva_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_voices <= 5'd1;
			cfg_q.steal_enable <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_ACTIVE_VOICES: cfg_q.active_voices <= pwdata[4:0];
				REG_STEAL_ENABLE: cfg_q.steal_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_ACTIVE_VOICES: prdata = {27'd0, cfg_q.active_voices};
			REG_STEAL_ENABLE: prdata = {31'd0, cfg_q.steal_enable};
			default: prdata = '0;
		endcase
	end

	pva_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.qstat  (qstat),
		.busy   (busy),
		.push   (push),
		.cmd    (push_cmd)
	);

	pva_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (push_cmd),
		.pop     (pop),
		.cmd_out (head_cmd),
		.qstat   (qstat)
	);

	pva_engine #(
		.MAX_VOICES (MAX_VOICES)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.qstat        (qstat),
		.cmd_in       (head_cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

### hw/rtl/pva_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the voice allocator, bound to the top level.
// Depends on pva_pkg and polyphonic_voice_allocator_core.
module pva_checker import pva_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input pva_in_t     item,
	input logic        busy,
	input logic        result_valid,
	input pva_out_t    result,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	// A result that is not the last is the off half of a steal.
	a_steal_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid && result.last)
		else $error("steal off-message not followed by its on-message");

	a_steal_off: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> result.velocity == 7'd0)
		else $error("steal off-message carries a velocity");

	a_steal_voice: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result.voice == $past(result.voice))
		else $error("steal transfer pair addresses two voices");

	a_steal_on: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result.velocity != 7'd0)
		else $error("steal on-message has zero velocity");

endmodule

bind polyphonic_voice_allocator_core pva_checker u_pva_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.item         (item),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata),
	.pready       (pready)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for polyphonic_voice_allocator_core: note and velocity
// commands in, voice on/off messages checked against a built-in allocator model.
// Depends on pva_pkg and the polyphonic_voice_allocator_core RTL.
module tb_top;
	import pva_pkg::*;

	localparam int NV = 16;
	localparam int SETTLE = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RAND_PHASES = 9;
	localparam int PHASE_ITEMS = 193;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	pva_in_t     item = '0;
	logic        busy;
	logic        result_valid;
	pva_out_t    result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Allocator model state and its copy of the registers.
	logic [4:0]  cfg_voices = 5'd1;
	bit          cfg_steal = 1'b0;
	bit [6:0]    held_vel;
	bit          v_on [NV];
	bit [6:0]    v_pitch [NV];
	bit [31:0]   v_stamp [NV];
	bit [31:0]   stamp_ctr;

	pva_in_t     note_events [$];
	pva_out_t    notes_due [$];
	logic        item_taken = 1'b0;
	int          send_gap_pct = 34;
	int          err_count = 0;
	int          cycle_count = 0;

	// Generator bookkeeping for building note-on / note-off pairs.
	bit [6:0]    gen_vel;
	bit [6:0]    sounding [$];

	polyphonic_voice_allocator_core #(.MAX_VOICES(NV)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.result_valid(result_valid),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(string what, int got, int want);
		if (err_count < 100)
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		err_count++;
	endtask

	function automatic void stamp_voice(int idx);
		v_stamp[idx] = stamp_ctr;
		stamp_ctr = stamp_ctr + 32'd1;
	endfunction

	function automatic void push_due(int idx, bit [6:0] p, bit [6:0] vel, bit fin);
		pva_out_t r;
		r.voice = 5'(idx + 1);
		r.pitch = p;
		r.velocity = vel;
		r.last = fin;
		notes_due.push_back(r);
	endfunction

	function automatic void allocate_voice(pva_in_t ev);
		int n;
		int oldest_on;
		int oldest_free;
		int hit;
		n = (cfg_voices == 5'd0) ? 1 : ((cfg_voices > NV) ? NV : int'(cfg_voices));
		oldest_on = -1;
		oldest_free = -1;
		hit = -1;
		if (ev.func == FUNC_SET_VEL) begin
			held_vel = ev.value;
			return;
		end
		// Plain unsigned stamp compare; the first voice scanned always qualifies.
		for (int i = 0; i < n; i++) begin
			if (v_on[i]) begin
				if (oldest_on < 0 || v_stamp[i] < v_stamp[oldest_on])
					oldest_on = i;
				if (v_pitch[i] == ev.value && (hit < 0 || v_stamp[i] < v_stamp[hit]))
					hit = i;
			end else if (oldest_free < 0 || v_stamp[i] < v_stamp[oldest_free]) begin
				oldest_free = i;
			end
		end
		if (held_vel != 7'd0) begin
			if (oldest_free >= 0) begin
				push_due(oldest_free, ev.value, held_vel, 1'b1);
				v_on[oldest_free] = 1'b1;
				v_pitch[oldest_free] = ev.value;
				stamp_voice(oldest_free);
			end else if (oldest_on >= 0 && cfg_steal) begin
				push_due(oldest_on, v_pitch[oldest_on], 7'd0, 1'b0);
				push_due(oldest_on, ev.value, held_vel, 1'b1);
				v_pitch[oldest_on] = ev.value;
				stamp_voice(oldest_on);
			end
		end else if (hit >= 0) begin
			v_on[hit] = 1'b0;
			stamp_voice(hit);
			push_due(hit, v_pitch[hit], 7'd0, 1'b1);
		end
	endfunction

	// Monitor: results are checked before the item taken at the same edge is
	// predicted, since a result can never belong to an item taken that cycle.
	always @(posedge clk) begin
		pva_out_t want;
		item_taken <= arst_n && start && !busy;
		if (arst_n && result_valid) begin
			if (notes_due.size() == 0) begin
				report_mismatch("result with nothing due", int'(result), 0);
			end else begin
				want = notes_due.pop_front();
				if (result.voice !== want.voice)
					report_mismatch("voice", result.voice, want.voice);
				if (result.pitch !== want.pitch)
					report_mismatch("pitch", result.pitch, want.pitch);
				if (result.velocity !== want.velocity)
					report_mismatch("velocity", result.velocity, want.velocity);
				if (result.last !== want.last)
					report_mismatch("last", result.last, want.last);
			end
		end
		if (arst_n && start && !busy)
			allocate_voice(item);
	end

	// Driver: start stays high with the same item until a transfer takes it.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || item_taken) begin
			if (note_events.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				item <= note_events.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("polyphonic_voice_allocator_core test failed");
			$finish;
		end
	end

	task automatic push_event(pva_func_t f, bit [6:0] v);
		pva_in_t ev;
		ev.func = f;
		ev.value = v;
		note_events.push_back(ev);
	endtask

	// Waits until every queued item is taken and every result has arrived, then
	// lets dropped notes still in the command queue finish their scan.
	task automatic wait_quiet();
		while (note_events.size() != 0 || start || notes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(pva_reg_t r, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_ACTIVE_VOICES: cfg_voices = data[4:0];
			REG_STEAL_ENABLE: cfg_steal = data[0];
			default: ;
		endcase
	endtask

	task automatic write_cfg(int voices, bit steal);
		apb_write(REG_ACTIVE_VOICES, 32'(voices));
		apb_write(REG_STEAL_ENABLE, {31'd0, steal});
	endtask

	task automatic gen_notes(int count);
		int made;
		int r;
		int k;
		bit fb;
		bit [6:0] p;
		made = 0;
		while (made < count) begin
			r = $urandom_range(99);
			if (r < 45) begin
				if (gen_vel == 7'd0) begin
					gen_vel = 7'($urandom_range(127, 1));
					push_event(FUNC_SET_VEL, gen_vel);
					made++;
				end
				// A narrow pitch range now and then gives repeated pitches.
				p = ($urandom_range(3) == 0) ? 7'($urandom_range(7)) : 7'($urandom_range(127));
				push_event(FUNC_NOTE, p);
				sounding.push_back(p);
				if (sounding.size() > 32)
					void'(sounding.pop_front());
				made++;
			end else if (r < 85) begin
				if (gen_vel != 7'd0) begin
					gen_vel = 7'd0;
					push_event(FUNC_SET_VEL, 7'd0);
					made++;
				end
				if (sounding.size() != 0 && $urandom_range(4) != 0) begin
					k = $urandom_range(sounding.size() - 1);
					p = sounding[k];
					sounding.delete(k);
				end else begin
					p = 7'($urandom_range(127));
				end
				push_event(FUNC_NOTE, p);
				made++;
			end else begin
				fb = $urandom_range(1);
				p = 7'($urandom_range(127));
				if (fb)
					gen_vel = p;
				push_event(fb ? FUNC_SET_VEL : FUNC_NOTE, p);
				made++;
			end
		end
	endtask

	initial begin
		int rnd_voices [RAND_PHASES] = '{16, 3, 1, 31, 5, 8, 0, 16, 12};
		bit rnd_steal [RAND_PHASES] = '{1, 0, 1, 1, 0, 1, 0, 1, 1};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Two voices, no stealing: unmatched release, fill, full pool drop,
		// release, unmatched release.
		write_cfg(2, 1'b0);
		push_event(FUNC_NOTE, 7'd60);
		push_event(FUNC_SET_VEL, 7'd127);
		push_event(FUNC_NOTE, 7'd0);
		push_event(FUNC_NOTE, 7'd127);
		push_event(FUNC_NOTE, 7'd64);
		push_event(FUNC_SET_VEL, 7'd0);
		push_event(FUNC_NOTE, 7'd127);
		push_event(FUNC_NOTE, 7'd5);
		push_event(FUNC_SET_VEL, 7'd1);
		wait_quiet();

		// A voice count of zero behaves as one voice, so this note steals it.
		write_cfg(0, 1'b1);
		push_event(FUNC_NOTE, 7'd64);
		push_event(FUNC_SET_VEL, 7'd0);
		push_event(FUNC_NOTE, 7'd64);
		wait_quiet();

		// A count above the pool size is clamped; the same pitch on two voices
		// is released oldest first.
		write_cfg(31, 1'b1);
		push_event(FUNC_SET_VEL, 7'd85);
		push_event(FUNC_NOTE, 7'd42);
		push_event(FUNC_NOTE, 7'd42);
		push_event(FUNC_SET_VEL, 7'd0);
		push_event(FUNC_NOTE, 7'd42);
		push_event(FUNC_NOTE, 7'd42);
		push_event(FUNC_NOTE, 7'd42);
		wait_quiet();

		gen_vel = 7'd0;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			send_gap_pct = (ph < 3) ? 34 : ((ph < 6) ? 79 : 0);
			write_cfg(rnd_voices[ph], rnd_steal[ph]);
			// The sender stops halfway until the allocator has gone quiet.
			gen_notes(PHASE_ITEMS / 2);
			wait_quiet();
			gen_notes(PHASE_ITEMS - PHASE_ITEMS / 2);
			wait_quiet();
		end

		if (err_count == 0)
			$display("polyphonic_voice_allocator_core test passed");
		else
			$display("polyphonic_voice_allocator_core test failed");
		$finish;
	end

endmodule

### sim.f
hw/rtl/pva_pkg.sv
hw/rtl/pva_front.sv
hw/rtl/pva_fifo.sv
hw/rtl/pva_engine.sv
hw/rtl/polyphonic_voice_allocator_core.sv
hw/rtl/pva_checker.sv
tb/sv/tb_top.sv
